// ===== rtl/core/rgbnv_pkg.sv =====
package rgbnv_pkg;

	// Fixed field widths of the pixel and result words.
	localparam int COLOR_W     = 8;
	localparam int PIXEL_W     = 3 * COLOR_W;
	localparam int SAMPLE_W    = 8;
	localparam int OFFSET_W    = 23;
	localparam int LUMA_W      = 22;
	localparam int COMP_W      = 2;
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_USER_W  = COMP_W + 1;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int SIZE_W      = 14;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	// Short queue between the front and back halves.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Sums of the conversion are 17 bits wide; their values fit in 16 bits once the rounding and offset terms are in.
	localparam int SUM_W = 17;

	localparam logic [SUM_W-1:0] Y_R = 17'd66;
	localparam logic [SUM_W-1:0] Y_G = 17'd129;
	localparam logic [SUM_W-1:0] Y_B = 17'd25;
	localparam logic [SUM_W-1:0] U_R = 17'd38;
	localparam logic [SUM_W-1:0] U_G = 17'd74;
	localparam logic [SUM_W-1:0] U_B = 17'd112;
	localparam logic [SUM_W-1:0] V_R = 17'd112;
	localparam logic [SUM_W-1:0] V_G = 17'd94;
	localparam logic [SUM_W-1:0] V_B = 17'd18;
	localparam logic [SUM_W-1:0] ROUND_BIAS  = 17'd128;
	// Rounding plus the chroma offset of 128 moved in front of the shift.
	localparam logic [SUM_W-1:0] CHROMA_BIAS = 17'd32896;
	localparam logic [SAMPLE_W-1:0] LUMA_OFFSET = 8'd16;

	typedef enum logic [COMP_W-1:0] {
		COMP_Y = 2'd0,
		COMP_V = 2'd1,
		COMP_U = 2'd2
	} comp_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
		logic [LUMA_W-1:0]   luma_addr;
		logic [OFFSET_W-1:0] chroma_addr;
		logic                chroma;
		logic                eof;
	} entry_t;

	// Effective frame size: zero reads as one, anything above the maximum as the maximum.
	function automatic logic [CFG_DATA_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [CFG_DATA_W-1:0] r;
		if (v == '0) begin
			r = CFG_DATA_W'(1);
		end else if (SIZE_W'(v) > maxv) begin
			r = maxv[CFG_DATA_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/rgbnv_front.sv =====
module rgbnv_front #(
	parameter int MAX_WIDTH  = rgbnv_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbnv_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rgbnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rgbnv_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rgbnv_pkg::PIXEL_W-1:0]       s_tdata,
	input  logic [rgbnv_pkg::QCNT_W-1:0]        queue_count,
	output logic                                push,
	output rgbnv_pkg::entry_t                   push_entry
);
	import rgbnv_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
	logic [CFG_DATA_W-1:0] w_eff, h_eff;
	logic [OFFSET_W-1:0]   frame_size_q;
	logic [1:0]            settle_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [LUMA_W-1:0]     luma_q;
	logic [OFFSET_W-1:0]   chroma_q;
	logic                  cfg_hit, accept, last_col, acc_eof, acc_chroma;
	logic [QCNT_W:0]       credit_used;

	logic                  valid_s1, valid_s2;
	logic [COLOR_W-1:0]    red_s1, green_s1, blue_s1;
	logic [LUMA_W-1:0]     luma_s1, luma_s2;
	logic [OFFSET_W-1:0]   chroma_s1, chroma_s2;
	logic                  chroma_flag_s1, chroma_flag_s2, eof_s1, eof_s2;
	logic [SUM_W-1:0]      y_sum_s2, u_sum_s2, v_sum_s2;
	logic [SUM_W-1:0]      r_ext, g_ext, b_ext;

	always_comb begin
		cfg_hit = 1'b0;
		case (cfg_index)
			REG_FRAME_WIDTH:  cfg_hit = cfg_valid;
			REG_FRAME_HEIGHT: cfg_hit = cfg_valid;
			default:          cfg_hit = 1'b0;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign w_eff = eff_size(frame_width_q, SIZE_W'(MAX_WIDTH));
	assign h_eff = eff_size(frame_height_q, SIZE_W'(MAX_HEIGHT));

	// Every pixel in flight in the front stages holds a queue slot in reserve.
	assign credit_used = (QCNT_W+1)'(queue_count) + (QCNT_W+1)'(valid_s1)
		+ (QCNT_W+1)'(valid_s2);
	// A register write takes the cycle, so no pixel is taken alongside it.
	assign s_tready = (settle_q == 2'd0) && !cfg_valid
		&& (credit_used < (QCNT_W+1)'(QUEUE_DEPTH));
	assign accept = s_tvalid && s_tready;

	assign last_col   = (SIZE_W'(col_q) + SIZE_W'(1)) >= SIZE_W'(w_eff);
	assign acc_eof    = last_col && ((SIZE_W'(row_q) + SIZE_W'(1)) >= SIZE_W'(h_eff));
	assign acc_chroma = !row_q[0] && !col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			settle_q       <= SETTLE_CYCLES;
			col_q          <= '0;
			row_q          <= '0;
			luma_q         <= '0;
			chroma_q       <= '0;
		end else begin
			if (cfg_hit) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default:          ;
				endcase
				// The new frame size is registered into frame_size_q, and from there into the chroma base.
				settle_q <= SETTLE_CYCLES;
				col_q    <= '0;
				row_q    <= '0;
				luma_q   <= '0;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
				if (settle_q == 2'd1) begin
					chroma_q <= frame_size_q;
				end
			end else if (accept) begin
				if (acc_eof) begin
					col_q    <= '0;
					row_q    <= '0;
					luma_q   <= '0;
					chroma_q <= frame_size_q;
				end else begin
					luma_q <= luma_q + LUMA_W'(1);
					if (acc_chroma) begin
						chroma_q <= chroma_q + OFFSET_W'(2);
					end
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		frame_size_q <= OFFSET_W'(w_eff) * OFFSET_W'(h_eff);
	end

	// Stage 1 holds the accepted pixel and its place in the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && !cfg_hit;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		red_s1         <= s_tdata[COLOR_W-1:0];
		green_s1       <= s_tdata[2*COLOR_W-1:COLOR_W];
		blue_s1        <= s_tdata[3*COLOR_W-1:2*COLOR_W];
		luma_s1        <= luma_q;
		chroma_s1      <= chroma_q;
		chroma_flag_s1 <= acc_chroma;
		eof_s1         <= acc_eof;
	end

	assign r_ext = SUM_W'(red_s1);
	assign g_ext = SUM_W'(green_s1);
	assign b_ext = SUM_W'(blue_s1);

	// The bias terms keep every sum non-negative, so the floor shift is a plain bit-select.
	always_ff @(posedge clk) begin
		y_sum_s2       <= Y_R * r_ext + Y_G * g_ext + Y_B * b_ext + ROUND_BIAS;
		u_sum_s2       <= U_B * b_ext + CHROMA_BIAS - U_R * r_ext - U_G * g_ext;
		v_sum_s2       <= V_R * r_ext + CHROMA_BIAS - V_G * g_ext - V_B * b_ext;
		luma_s2        <= luma_s1;
		chroma_s2      <= chroma_s1;
		chroma_flag_s2 <= chroma_flag_s1;
		eof_s2         <= eof_s1;
	end

	// The sums never leave 0..255 after the shift, so no clamp is needed.
	assign push = valid_s2;
	assign push_entry.y           = y_sum_s2[15:8] + LUMA_OFFSET;
	assign push_entry.u           = u_sum_s2[15:8];
	assign push_entry.v           = v_sum_s2[15:8];
	assign push_entry.luma_addr   = luma_s2;
	assign push_entry.chroma_addr = chroma_s2;
	assign push_entry.chroma      = chroma_flag_s2;
	assign push_entry.eof         = eof_s2;

`ifndef ASSERT_OFF
	a_eof_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && acc_eof) |=> (col_q == '0 && row_q == '0 && luma_q == '0))
		else $error("frame counters did not restart after the last pixel");
`endif

endmodule

// ===== rtl/core/rgbnv_queue.sv =====
module rgbnv_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  rgbnv_pkg::entry_t            push_entry,
	input  logic                         pop,
	output rgbnv_pkg::entry_t            head,
	output logic                         empty,
	output logic [rgbnv_pkg::QCNT_W-1:0] count
);
	import rgbnv_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q != QCNT_W'(QUEUE_DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");
`endif

endmodule

// ===== rtl/core/rgbnv_back.sv =====
module rgbnv_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rgbnv_pkg::entry_t                head,
	input  logic                             empty,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rgbnv_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [rgbnv_pkg::OUT_USER_W-1:0] m_tuser,
	output logic                             m_tlast
);
	import rgbnv_pkg::*;

	typedef enum logic [2:0] {
		ST_LUMA = 3'b001,
		ST_V    = 3'b010,
		ST_U    = 3'b100
	} phase_t;

	phase_t              state_q, state_d;
	logic                load, last_w;
	comp_t               comp_w;
	logic [SAMPLE_W-1:0] sample_w;
	logic [OFFSET_W-1:0] offset_w;

	logic                out_valid_q;
	comp_t               comp_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                last_q, eof_q;

	// The output register takes a new word whenever it is empty or being drained.
	assign load = !out_valid_q || m_tready;

	always_comb begin
		comp_w   = COMP_Y;
		sample_w = head.y;
		offset_w = OFFSET_W'(head.luma_addr);
		last_w   = !head.chroma;
		state_d  = ST_LUMA;
		case (state_q)
			ST_LUMA: begin
				comp_w   = COMP_Y;
				sample_w = head.y;
				offset_w = OFFSET_W'(head.luma_addr);
				last_w   = !head.chroma;
				state_d  = head.chroma ? ST_V : ST_LUMA;
			end
			ST_V: begin
				comp_w   = COMP_V;
				sample_w = head.v;
				offset_w = head.chroma_addr;
				last_w   = 1'b0;
				state_d  = ST_U;
			end
			ST_U: begin
				comp_w   = COMP_U;
				sample_w = head.u;
				offset_w = head.chroma_addr + OFFSET_W'(1);
				last_w   = 1'b1;
				state_d  = ST_LUMA;
			end
			default: begin
				state_d = ST_LUMA;
			end
		endcase
	end

	assign pop = load && !empty && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LUMA;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			comp_q   <= comp_w;
			sample_q <= sample_w;
			offset_q <= offset_w;
			last_q   <= last_w;
			eof_q    <= head.eof;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, offset_q, sample_q};
	assign m_tuser  = {eof_q, comp_q};
	assign m_tlast  = last_q;

`ifndef ASSERT_OFF
	a_chroma_phase_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LUMA) |-> (!empty && head.chroma))
		else $error("chroma phase without a chroma pixel at the queue head");
	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(state_q))
		else $error("sample sequence advanced while the output was stalled");
`endif

endmodule

// ===== rtl/core/rgb_to_nv21_converter_core.sv =====
// RGB to NV21 converter. Each RGB word on the s_ side is one pixel of a frame in raster
// order; frame_width (register 0) and frame_height (register 1) set the frame size, zero
// reading as one and values above MAX_WIDTH / MAX_HEIGHT as that maximum. Every pixel
// produces a luma word (BT.601, offset 16) at the next luma-plane offset; pixels on an
// even row and even column also produce a V word and then a U word at the next two
// interleaved chroma offsets after the luma plane. m_tlast marks the last word of a pixel.
// The output side delivers one word per cycle while m_tready is high and the queue holds a
// pixel, so a pixel yields one word, or three when it carries chroma: six words per
// two-by-two block. Pixels pass two conversion stages into a four-entry queue, then the
// output register. After reset and after a write to either size register the input is
// held off while the frame size product settles; such a write also restarts the frame.
// The input is also held off in any cycle in which a register write is offered.
module rgb_to_nv21_converter_core #(
	parameter int MAX_WIDTH  = rgbnv_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbnv_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rgbnv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rgbnv_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rgbnv_pkg::PIXEL_W-1:0]     s_tdata,   // red, green, blue
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rgbnv_pkg::OUT_DATA_W-1:0]  m_tdata,   // sample, byte_offset
	output logic [rgbnv_pkg::OUT_USER_W-1:0]  m_tuser,   // component, end_of_frame
	output logic                              m_tlast    // last_of_pixel
);
	import rgbnv_pkg::*;

	entry_t            push_entry, head;
	logic              push, pop, empty;
	logic [QCNT_W-1:0] queue_count;

	rgbnv_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_count(queue_count),
		.push       (push),
		.push_entry (push_entry)
	);

	rgbnv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (queue_count)
	);

	rgbnv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== dv/testbench.sv =====
module testbench;
	import rgbnv_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;

	// Indexes with no register behind them; writes there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	typedef struct {
		comp_t               comp;
		logic [SAMPLE_W-1:0] sample;
		logic [OFFSET_W-1:0] offset;
		logic                last;
		logic                eof;
	} nv21_word_t;

	class nv21_scoreboard;
		nv21_word_t            pending_words[$];
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		int unsigned           col;
		int unsigned           row;
		int unsigned           luma_addr;
		int unsigned           chroma_addr;
		int                    errors;
		int                    pixels;
		int                    words;
		int                    frames;

		function new();
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			errors = 0;
			pixels = 0;
			words = 0;
			frames = 0;
			restart_frame();
		endfunction

		// A size of zero counts as one, anything above the maximum as the maximum.
		function int unsigned effective_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
			if (v == 0) return 1;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function void restart_frame();
			col = 0;
			row = 0;
			luma_addr = 0;
			chroma_addr = (effective_size(width_reg, MAX_WIDTH_DEF) *
				effective_size(height_reg, MAX_HEIGHT_DEF)) & 32'h7F_FFFF;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			if (index == REG_FRAME_WIDTH) begin
				width_reg = value;
				restart_frame();
			end else if (index == REG_FRAME_HEIGHT) begin
				height_reg = value;
				restart_frame();
			end
		endfunction

		function logic [SAMPLE_W-1:0] luma_sample(int acc);
			int t;
			t = acc + 128;
			if (t < 0) return 8'h00;
			t = t / 256 + 16;
			if (t > 255) return 8'hFF;
			return t[SAMPLE_W-1:0];
		endfunction

		// The chroma offset of 128 is folded in before the shift so the division stays positive.
		function logic [SAMPLE_W-1:0] chroma_sample(int acc);
			int t;
			t = acc + 128 + 32768;
			if (t < 0) return 8'h00;
			t = t / 256;
			if (t > 255) return 8'hFF;
			return t[SAMPLE_W-1:0];
		endfunction

		function void push_word(comp_t comp, logic [SAMPLE_W-1:0] smp, int unsigned off,
			logic last, logic eof);
			nv21_word_t w;
			w.comp = comp;
			w.sample = smp;
			w.offset = off[OFFSET_W-1:0];
			w.last = last;
			w.eof = eof;
			pending_words.push_back(w);
		endfunction

		function void add_pixel(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
			logic [COLOR_W-1:0] blue);
			int          r;
			int          g;
			int          b;
			int unsigned w;
			int unsigned h;
			bit          last_col;
			bit          eof;
			bit          chroma;
			r = red;
			g = green;
			b = blue;
			w = effective_size(width_reg, MAX_WIDTH_DEF);
			h = effective_size(height_reg, MAX_HEIGHT_DEF);
			last_col = (col + 1 >= w);
			eof = last_col && (row + 1 >= h);
			chroma = (row % 2 == 0) && (col % 2 == 0);
			push_word(COMP_Y, luma_sample(66 * r + 129 * g + 25 * b), luma_addr, !chroma, eof);
			luma_addr = (luma_addr + 1) & 32'h3F_FFFF;
			if (chroma) begin
				push_word(COMP_V, chroma_sample(112 * r - 94 * g - 18 * b), chroma_addr,
					1'b0, eof);
				chroma_addr = (chroma_addr + 1) & 32'h7F_FFFF;
				push_word(COMP_U, chroma_sample(-38 * r - 74 * g + 112 * b), chroma_addr,
					1'b1, eof);
				chroma_addr = (chroma_addr + 1) & 32'h7F_FFFF;
			end
			if (eof) begin
				restart_frame();
				frames++;
			end else if (last_col) begin
				col = 0;
				row = (row + 1) & 32'h7FF;
			end else begin
				col = (col + 1) & 32'h7FF;
			end
			pixels++;
		endfunction

		function void check_word(logic [COMP_W-1:0] comp, logic [SAMPLE_W-1:0] smp,
			logic [OFFSET_W-1:0] off, logic last, logic eof);
			nv21_word_t e;
			words++;
			if (pending_words.size() == 0) begin
				$error("output word with nothing expected: component %0d, byte_offset %0d",
					comp, off);
				errors++;
				return;
			end
			e = pending_words.pop_front();
			if (comp !== e.comp) begin
				$error("component: expected %0d, got %0d", e.comp, comp);
				errors++;
			end
			if (smp !== e.sample) begin
				$error("sample: expected %0d, got %0d", e.sample, smp);
				errors++;
			end
			if (off !== e.offset) begin
				$error("byte_offset: expected %0d, got %0d", e.offset, off);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_of_pixel: expected %0d, got %0d", e.last, last);
				errors++;
			end
			if (eof !== e.eof) begin
				$error("end_of_frame: expected %0d, got %0d", e.eof, eof);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [PIXEL_W-1:0]     s_tdata;   // red, green, blue
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;   // sample, byte_offset
	logic [OUT_USER_W-1:0]  m_tuser;   // component, end_of_frame
	logic                   m_tlast;   // last_of_pixel

	nv21_scoreboard sb = new();
	rx_mode_t       rx_mode = RX_ALWAYS;
	int             tx_gap_max = 0;
	int             burst_left = 0;
	int             idle_cycles = 0;
	int             sizes_run = 0;
	bit             hold_req = 1'b0;

	rgb_to_nv21_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_word(m_tuser[COMP_W-1:0], m_tdata[SAMPLE_W-1:0],
				m_tdata[SAMPLE_W+OFFSET_W-1:SAMPLE_W], m_tlast, m_tuser[COMP_W]);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: a per-phase stall pattern, plus one long hold-off on request.
	initial begin
		int pat;
		pat = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pat++;
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					RX_PATTERN: m_tready <= (pat % 5) < 3;
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(index, value);
	endtask

	task automatic push_pixel(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
		input logic [COLOR_W-1:0] blue);
		if (tx_gap_max != 0 && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left != 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {blue, green, red};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.add_pixel(red, green, blue);
	endtask

	// Components lean toward the ends of the range now and then.
	function automatic logic [COLOR_W-1:0] random_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_random(input int n);
		repeat (n) push_pixel(random_byte(), random_byte(), random_byte());
	endtask

	task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		sizes_run++;
	endtask

	initial begin
		logic [PIXEL_W-1:0] corners[12];
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
			24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010203, 24'hFE017F, 24'h10EB40};
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size, first row: pure colors and the ends of each component.
		sizes_run = 1;
		foreach (corners[i]) push_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);

		// Writes to unused indexes must not restart the frame.
		rx_mode = RX_RANDOM;
		tx_gap_max = 3;
		write_reg(REG_UNUSED_2, 12'd5);
		write_reg(REG_UNUSED_3, 12'hFFF);
		push_random(4);

		rx_mode = RX_ALWAYS;
		tx_gap_max = 0;
		set_frame_size(12'd0, 12'd0);
		push_random(8);

		rx_mode = RX_PATTERN;
		tx_gap_max = 4;
		set_frame_size(12'hFFF, 12'hFFF);
		push_random(12);
		set_frame_size(12'd1, 12'hFFF);
		push_random(12);

		// Odd size with a long output stall while the input keeps coming.
		rx_mode = RX_RANDOM;
		tx_gap_max = 0;
		set_frame_size(12'd3, 12'd3);
		hold_req = 1'b1;
		push_random(30);

		for (int p = 0; p < 8; p++) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			tx_gap_max = $urandom_range(0, 6);
			set_frame_size(CFG_DATA_W'($urandom_range(1, 9)), CFG_DATA_W'($urandom_range(1, 7)));
			push_random(10);
			if (p == 3) wait_drained();
			push_random(8);
		end

		wait_drained();
		repeat (3 * SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d pixels, %0d output words and %0d whole frames over %0d sizes,",
			sb.pixels, sb.words, sb.frames, sizes_run);
		$display("from one pixel up to the largest frame, with unused register writes and stalls.");
		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
